@@ rtl/ssc_pkg.sv @@
// Shared types, constants and field layouts for the station sighting cache.
package ssc_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam int ADDR_W    = 48;
    localparam int STR_W     = 8;
    localparam int TIME_W    = 63;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 32;
    localparam int OUTCOME_W = 2;
    localparam int GROUP_BIT = 40;

    // Input stream: addr, strength, time, then one pad bit up to a whole byte.
    localparam int IN_RAW_W = ADDR_W + STR_W + TIME_W;
    localparam int IN_W     = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_W    = ((OUTCOME_W + SLOT_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_IGNORED  = 2'd0,
        OUT_HIT      = 2'd1,
        OUT_INSERTED = 2'd2,
        OUT_REPLACED = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] last_seen;
        logic [STR_W-1:0]  strength;
        logic [ADDR_W-1:0] addr;
    } entry_t;

    typedef struct packed {
        logic accept;   // capture the incoming sighting and restart the scan
        logic scan;     // step the table walk
        logic finish;   // write back, update counters and load the result
    } ssc_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } ssc_sts_t;

endpackage

@@ rtl/station_sighting_cache.sv @@
// Top level of the station sighting cache: controller and datapath joined by command and status.
// After the accepting edge the walk reads the valid entries at one entry per cycle behind a
// registered read; once the output register is free, a write-back step updates the table and
// counters and loads the result. A match ends the walk early; a group address or an empty
// table ends it with no entry compared. A new sighting is taken only after the last is written
// back; reset clears the counters and control state at once, and the table needs no clearing pass.
module station_sighting_cache #(
    parameter int TABLE_ENTRIES = ssc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,

    // Sighting input. s_tdata from bit 0: station_addr[47:0], signal_strength[7:0],
    // time_now[62:0], one zero pad bit.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ssc_pkg::IN_W-1:0]  s_tdata,

    // Result output. m_tdata from bit 0: outcome[1:0], slot_used[5:0], unique_seen[31:0].
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ssc_pkg::OUT_W-1:0] m_tdata
);

    // The controller walks IDLE, SCAN and FINISH. A new transaction is accepted only in
    // IDLE, but a finished result may still wait in the output register at that time, so
    // the input side does not wait on the output side. FINISH holds until the output
    // register is free, and only then are the table and the counters updated, so every
    // sighting is counted exactly once.
    ssc_pkg::ssc_cmd_t cmd;
    ssc_pkg::ssc_sts_t sts;

    ssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the station table as a memory with one registered read port.
    // During the walk it compares each entry with the captured address and keeps the
    // entry with the smallest last-seen time, the first one winning on equal times.
    ssc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

@@ rtl/ssc_ctrl.sv @@
// Controller state machine that sequences accept, table scan and write-back.
module ssc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ssc_pkg::ssc_sts_t sts,
    output ssc_pkg::ssc_cmd_t cmd
);

    ssc_pkg::state_t state_reg;
    ssc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ssc_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ssc_pkg::ST_SCAN;
                end
            end
            ssc_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ssc_pkg::ST_FINISH;
                end
            end
            ssc_pkg::ST_FINISH:
            begin
                // Hold here until the output register can take the result.
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ssc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/ssc_datapath.sv @@
// Datapath: station table memory, scan compare and oldest tracking, counters, result register.
module ssc_datapath #(
    parameter int TABLE_ENTRIES = ssc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ssc_pkg::IN_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [ssc_pkg::OUT_W-1:0] m_tdata,
    input  ssc_pkg::ssc_cmd_t        cmd,
    output ssc_pkg::ssc_sts_t        sts
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    // Station table, one word per entry.
    ssc_pkg::entry_t mem [TABLE_ENTRIES];
    ssc_pkg::entry_t rd_data_reg;

    // Captured sighting.
    logic [ssc_pkg::ADDR_W-1:0] addr_reg;
    logic [ssc_pkg::STR_W-1:0]  str_reg;
    logic [ssc_pkg::TIME_W-1:0] time_reg;

    // Scan state.
    logic [CW-1:0] issue_idx_reg;
    logic [AW-1:0] rd_idx_reg;
    logic          rd_valid_reg;
    logic          hit_reg;
    logic [AW-1:0] hit_idx_reg;
    logic [ssc_pkg::TIME_W-1:0] min_time_reg;
    logic [AW-1:0] min_idx_reg;

    // Persistent counters.
    logic [CW-1:0]               fill_reg;
    logic [ssc_pkg::COUNT_W-1:0] unique_reg;

    // Result register.
    logic                        out_valid_reg;
    ssc_pkg::outcome_t           out_outcome_reg;
    logic [ssc_pkg::SLOT_W-1:0]  out_slot_reg;
    logic [ssc_pkg::COUNT_W-1:0] out_unique_reg;

    logic                        group;
    logic                        issue_ok;
    logic                        hit_now;
    logic                        table_full;
    logic                        take_min;
    ssc_pkg::outcome_t           outcome;
    logic [AW-1:0]               slot;
    logic                        is_new;
    logic [ssc_pkg::COUNT_W-1:0] unique_next;

    assign group      = addr_reg[ssc_pkg::GROUP_BIT];
    assign issue_ok   = (issue_idx_reg < fill_reg);
    assign hit_now    = cmd.scan && rd_valid_reg && (rd_data_reg.addr == addr_reg);
    assign table_full = (fill_reg == CW'(TABLE_ENTRIES));
    // Strict less-than keeps the lowest index on equal times.
    assign take_min   = (rd_idx_reg == '0) || (rd_data_reg.last_seen < min_time_reg);

    assign sts.scan_done = group || hit_now || (!issue_ok && !rd_valid_reg);
    assign sts.out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        priority if (group)
        begin
            outcome = ssc_pkg::OUT_IGNORED;
            slot    = '0;
        end
        else if (hit_reg)
        begin
            outcome = ssc_pkg::OUT_HIT;
            slot    = hit_idx_reg;
        end
        else if (!table_full)
        begin
            outcome = ssc_pkg::OUT_INSERTED;
            slot    = fill_reg[AW-1:0];
        end
        else
        begin
            outcome = ssc_pkg::OUT_REPLACED;
            slot    = min_idx_reg;
        end
    end

    assign is_new      = (outcome == ssc_pkg::OUT_INSERTED) || (outcome == ssc_pkg::OUT_REPLACED);
    assign unique_next = is_new ? (unique_reg + ssc_pkg::COUNT_W'(1)) : unique_reg;

    // Memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[issue_idx_reg[AW-1:0]];
        if (cmd.finish && (outcome != ssc_pkg::OUT_IGNORED))
        begin
            mem[slot] <= '{last_seen: time_reg, strength: str_reg, addr: addr_reg};
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            addr_reg <= s_tdata[ssc_pkg::ADDR_W-1:0];
            str_reg  <= s_tdata[ssc_pkg::ADDR_W +: ssc_pkg::STR_W];
            time_reg <= s_tdata[ssc_pkg::ADDR_W + ssc_pkg::STR_W +: ssc_pkg::TIME_W];
        end
        rd_idx_reg <= issue_idx_reg[AW-1:0];
        if (hit_now && !hit_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (cmd.scan && rd_valid_reg && take_min)
        begin
            min_time_reg <= rd_data_reg.last_seen;
            min_idx_reg  <= rd_idx_reg;
        end
        if (cmd.finish)
        begin
            out_outcome_reg <= outcome;
            out_slot_reg    <= ssc_pkg::SLOT_W'(slot);
            out_unique_reg  <= unique_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_idx_reg <= '0;
            rd_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            fill_reg      <= '0;
            unique_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                issue_idx_reg <= '0;
                rd_valid_reg  <= 1'b0;
                hit_reg       <= 1'b0;
            end
            else
            begin
                rd_valid_reg <= cmd.scan && issue_ok;
                if (cmd.scan && issue_ok)
                begin
                    issue_idx_reg <= issue_idx_reg + CW'(1);
                end
                if (hit_now)
                begin
                    hit_reg <= 1'b1;
                end
            end

            if (cmd.finish)
            begin
                unique_reg <= unique_next;
                if (outcome == ssc_pkg::OUT_INSERTED)
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_unique_reg, out_slot_reg, out_outcome_reg};

endmodule
